/* design/wpt_pkg.sv */
// ----------------------------------------------------------------------------
// wpt_pkg
// shared widths, tap and rounding helpers, and the control bundle for the mac
// ----------------------------------------------------------------------------
package wpt_pkg;

    localparam int DATA_W = 32;
    localparam int TAP_W  = 16;
    localparam int PROD_W = DATA_W + TAP_W;
    localparam int ACC_W  = 56;
    localparam int ADDR_W = 6;
    localparam int DEPTH  = 64;
    localparam int CFG_W  = 64;

    localparam logic [2:0] REG_LOG_LENGTH     = 3'd0;
    localparam logic [2:0] REG_STAGE_COUNT    = 3'd1;
    localparam logic [2:0] REG_FILTER_LENGTH  = 3'd2;
    localparam logic [2:0] REG_CIRCULAR_SHIFT = 3'd3;
    localparam logic [2:0] REG_LOW_FIRST      = 3'd4;
    localparam logic [2:0] REG_LOW_SECOND     = 3'd5;
    localparam logic [2:0] REG_HIGH_FIRST     = 3'd6;
    localparam logic [2:0] REG_HIGH_SECOND    = 3'd7;

    typedef struct packed {
        logic                    valid;
        logic                    clear;
        logic signed [TAP_W-1:0] coef_a;
        logic signed [TAP_W-1:0] coef_b;
    } t_mac_ctl;

    function automatic logic signed [TAP_W-1:0] tap_of(
        input logic [CFG_W-1:0] first,
        input logic [CFG_W-1:0] second,
        input logic [2:0]       t
    );
        logic [CFG_W-1:0] w;
        w = t[2] ? second : first;
        return $signed(w[TAP_W*t[1:0] +: TAP_W]);
    endfunction

    function automatic logic [DATA_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] b;
        logic signed [ACC_W-15:0] q;
        b = a + ACC_W'(8192);
        q = (ACC_W-14)'(b >>> 14);
        if (q > (ACC_W-14)'(64'sh7fffffff)) begin
            return 32'h7fffffff;
        end else if (q < -(ACC_W-14)'(64'sh80000000)) begin
            return 32'h80000000;
        end else begin
            return q[DATA_W-1:0];
        end
    endfunction

endpackage

/* design/wpt_ram.sv */
// ----------------------------------------------------------------------------
// wpt_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module wpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/wpt_mac.sv */
// ----------------------------------------------------------------------------
// wpt_mac
// dual multiply-accumulate unit, one registered product stage per lane
// ----------------------------------------------------------------------------
module wpt_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  wpt_pkg::t_mac_ctl                 i_ctl,
    input  logic signed [wpt_pkg::DATA_W-1:0] i_data,
    output logic signed [wpt_pkg::ACC_W-1:0]  o_acc_a,
    output logic signed [wpt_pkg::ACC_W-1:0]  o_acc_b
);

    logic signed [wpt_pkg::PROD_W-1:0] r_prod_a;
    logic signed [wpt_pkg::PROD_W-1:0] r_prod_b;
    logic                              r_prod_valid;
    logic signed [wpt_pkg::ACC_W-1:0]  r_acc_a;
    logic signed [wpt_pkg::ACC_W-1:0]  r_acc_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_acc_a      <= '0;
            r_acc_b      <= '0;
        end else begin
            r_prod_valid <= i_ctl.valid;
            if (i_ctl.clear) begin
                r_acc_a <= '0;
                r_acc_b <= '0;
            end else if (r_prod_valid) begin
                r_acc_a <= r_acc_a + wpt_pkg::ACC_W'(r_prod_a);
                r_acc_b <= r_acc_b + wpt_pkg::ACC_W'(r_prod_b);
            end
        end
        r_prod_a <= i_data * i_ctl.coef_a;
        r_prod_b <= i_data * i_ctl.coef_b;
    end

    assign o_acc_a = r_acc_a;
    assign o_acc_b = r_acc_b;

endmodule

/* design/wavelet_packet_transform_1d_top.sv */
// ----------------------------------------------------------------------------
// wavelet_packet_transform_1d_top
// periodic 1d wavelet packet transform over a tile of up to 64 samples
// ----------------------------------------------------------------------------
// channel   direction  transfer when               payload
// input     in         start && !busy              i_action, i_sample_value
// result    out        o_valid (one cycle)         o_out_value, o_out_last
// config    in         i_cfg_we                    i_cfg_idx, i_cfg_data
//
// a sample that does not complete the tile is only stored and counted
// the completing sample runs the transform: each computed value issues its
// taps to the shared mac, drains and is written back, each moved value is
// read and written, then the tile streams out at one value per cycle
// reset clears control state only; the stores hold no reset value
// results cannot be stalled; busy stays high until the last read is issued
// ----------------------------------------------------------------------------
module wavelet_packet_transform_1d_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_action,
    input  logic signed [wpt_pkg::DATA_W-1:0] i_sample_value,
    output logic                              o_valid,
    output logic signed [wpt_pkg::DATA_W-1:0] o_out_value,
    output logic                              o_out_last,
    input  logic                              i_cfg_we,
    input  logic [2:0]                        i_cfg_idx,
    input  logic [wpt_pkg::CFG_W-1:0]         i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_ISSUE, S_D1, S_D2, S_WR, S_CP_RD, S_CP_WR, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        PH_FWD_A, PH_FWD_B, PH_FWD_C, PH_FWD_FIN, PH_INV_CP, PH_INV_SY
    } t_phase;

    localparam logic [5:0] ALL1 = 6'h3f;

    logic [2:0]                r_log_length;
    logic [2:0]                r_stage_count;
    logic [3:0]                r_filter_length;
    logic [4:0]                r_circ;
    logic [wpt_pkg::CFG_W-1:0] r_low_first;
    logic [wpt_pkg::CFG_W-1:0] r_low_second;
    logic [wpt_pkg::CFG_W-1:0] r_high_first;
    logic [wpt_pkg::CFG_W-1:0] r_high_second;

    t_state     r_state;
    t_phase     r_phase;
    logic [5:0] r_load_count;
    logic [2:0] r_lv;
    logic [4:0] r_blk;
    logic [5:0] r_j;
    logic [2:0] r_t;
    logic       r_sub;
    logic       r_res_det;
    logic       r_v1;
    logic signed [wpt_pkg::TAP_W-1:0] r_ca;
    logic signed [wpt_pkg::TAP_W-1:0] r_cb;
    logic       r_ov1;
    logic       r_ol1;
    logic       r_out_valid;
    logic       r_out_last;
    logic [wpt_pkg::DATA_W-1:0] r_out_value;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_length    <= 3'd6;
            r_stage_count   <= 3'd1;
            r_filter_length <= 4'd2;
            r_circ          <= '0;
            r_low_first     <= '0;
            r_low_second    <= '0;
            r_high_first    <= '0;
            r_high_second   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wpt_pkg::REG_LOG_LENGTH:     r_log_length    <= i_cfg_data[2:0];
                wpt_pkg::REG_STAGE_COUNT:    r_stage_count   <= i_cfg_data[2:0];
                wpt_pkg::REG_FILTER_LENGTH:  r_filter_length <= i_cfg_data[3:0];
                wpt_pkg::REG_CIRCULAR_SHIFT: r_circ          <= i_cfg_data[4:0];
                wpt_pkg::REG_LOW_FIRST:      r_low_first     <= i_cfg_data;
                wpt_pkg::REG_LOW_SECOND:     r_low_second    <= i_cfg_data;
                wpt_pkg::REG_HIGH_FIRST:     r_high_first    <= i_cfg_data;
                wpt_pkg::REG_HIGH_SECOND:    r_high_second   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective configuration
    logic [2:0] p;
    logic [2:0] st_eff;
    logic [3:0] len4;
    logic [5:0] s6;
    logic [6:0] n7;
    logic [6:0] cnt7;
    logic [5:0] mask_n;

    always_comb begin
        case (r_log_length)
            3'd0:    p = 3'd1;
            3'd7:    p = 3'd6;
            default: p = r_log_length;
        endcase
        st_eff = (r_stage_count > p) ? p : r_stage_count;
        len4   = r_filter_length & 4'he;
        if (len4 < 4'd2) begin
            len4 = 4'd2;
        end else if (len4 > 4'd8) begin
            len4 = 4'd8;
        end
    end

    assign s6     = {r_circ[4], r_circ[4:1], 1'b0};
    assign n7     = 7'd1 << p;
    assign cnt7   = {1'b0, r_load_count} + 7'd1;
    assign mask_n = ~(ALL1 << p);

    // loop geometry
    logic [2:0] mlog;
    logic [3:0] mlog1;
    logic [5:0] mk;
    logic [5:0] m6;
    logic [5:0] mh6;
    logic [5:0] mmask;
    logic [5:0] f6;
    logic [5:0] o6;
    logic [4:0] last_blk;
    logic [5:0] last_j;
    logic       swap;
    logic [5:0] jg;
    logic [5:0] fwd_addr;
    logic [5:0] inv_addr;
    logic [5:0] rd_addr;
    logic [5:0] wr_addr;

    assign mlog     = p - r_lv;
    assign mlog1    = {1'b0, mlog} + 4'd1;
    assign mk       = ~(ALL1 << mlog);
    assign m6       = 6'd1 << mlog;
    assign mh6      = m6 >> 1;
    assign mmask    = ~(ALL1 << mlog1);
    assign f6       = {1'b0, r_blk} << mlog1;
    assign o6       = f6 + m6;
    assign last_blk = (r_lv == 3'd0) ? 5'd0 : 5'((6'd1 << (r_lv - 3'd1)) - 6'd1);
    assign swap     = (r_lv > 3'd1) && !r_blk[0];
    assign jg       = ((r_j - {3'b0, r_t} - s6) & mmask) >> 1;
    assign fwd_addr = f6 + (({r_j[4:0], 1'b0} + {3'b0, r_t} + s6) & mk);
    assign inv_addr = f6 + jg + (r_sub ? m6 : 6'd0);

    always_comb begin
        case (r_phase)
            PH_FWD_A, PH_FWD_B: last_j = mk >> 1;
            PH_FWD_C:           last_j = mk >> 1;
            PH_FWD_FIN:         last_j = mk;
            default:            last_j = mmask;
        endcase
        case (r_phase)
            PH_FWD_A, PH_FWD_B: rd_addr = fwd_addr;
            PH_FWD_C:           rd_addr = o6 + mh6 + r_j;
            PH_FWD_FIN:         rd_addr = f6 + r_j;
            PH_INV_CP:          rd_addr = f6 + (swap ? (r_j ^ m6) : r_j);
            default:            rd_addr = inv_addr;
        endcase
        if (r_state == S_OUT) begin
            rd_addr = r_j;
        end
        case (r_phase)
            PH_FWD_A:   wr_addr = (r_lv == 3'd0) ? r_j : o6 + r_j;
            PH_FWD_B:   wr_addr = o6 + mh6 + r_j;
            PH_FWD_FIN: wr_addr = f6 + m6 + r_j;
            default:    wr_addr = f6 + r_j;
        endcase
    end

    // taps and issue control
    logic signed [wpt_pkg::TAP_W-1:0] h_t;
    logic signed [wpt_pkg::TAP_W-1:0] g_t;
    logic signed [wpt_pkg::TAP_W-1:0] coef_a;
    logic signed [wpt_pkg::TAP_W-1:0] coef_b;
    logic is_inv;
    logic issue_last;
    logic j_last;

    assign h_t    = wpt_pkg::tap_of(r_low_first, r_low_second, r_t);
    assign g_t    = wpt_pkg::tap_of(r_high_first, r_high_second, r_t);
    assign is_inv = (r_phase == PH_INV_SY);
    assign coef_a = (r_phase == PH_FWD_B) ? g_t : (is_inv && !r_sub) ? g_t : h_t;
    assign coef_b = (r_phase == PH_FWD_B) ? h_t : g_t;
    assign issue_last = is_inv ? (r_sub && ({1'b0, r_t} + 4'd2 >= len4))
                               : ({1'b0, r_t} == len4 - 4'd1);
    assign j_last = (r_j == last_j);

    // stores and mac
    logic [wpt_pkg::DATA_W-1:0] sample_rd;
    logic [wpt_pkg::DATA_W-1:0] scratch_rd;
    logic [wpt_pkg::DATA_W-1:0] detail_rd;
    logic signed [wpt_pkg::ACC_W-1:0] acc_a;
    logic signed [wpt_pkg::ACC_W-1:0] acc_b;
    logic [wpt_pkg::DATA_W-1:0] rs_a;
    logic [wpt_pkg::DATA_W-1:0] rs_b;
    logic       load;
    logic       wr_fwd;
    logic       sample_we;
    logic [5:0] sample_waddr;
    logic [wpt_pkg::DATA_W-1:0] sample_wdata;
    logic       scratch_we;
    logic [wpt_pkg::DATA_W-1:0] scratch_wdata;
    logic       detail_we;
    logic [wpt_pkg::DATA_W-1:0] detail_wdata;
    logic [wpt_pkg::DATA_W-1:0] mac_data;
    wpt_pkg::t_mac_ctl mac_ctl;

    assign busy   = (r_state != S_IDLE);
    assign load   = start && !busy;
    assign rs_a   = wpt_pkg::round_sat(acc_a);
    assign rs_b   = wpt_pkg::round_sat(acc_b);
    assign wr_fwd = (r_state == S_WR) && (r_phase == PH_FWD_A || r_phase == PH_FWD_B);

    assign sample_we    = load || ((r_state == S_WR) && is_inv);
    assign sample_waddr = load ? r_load_count : wr_addr;
    assign sample_wdata = load ? i_sample_value : rs_a;

    assign scratch_we    = wr_fwd || ((r_state == S_CP_WR) &&
                           (r_phase == PH_FWD_C || r_phase == PH_INV_CP));
    assign scratch_wdata = wr_fwd ? rs_a : (r_phase == PH_FWD_C) ? scratch_rd : sample_rd;

    assign detail_we    = wr_fwd || ((r_state == S_CP_WR) &&
                          (r_phase == PH_FWD_C || r_phase == PH_FWD_FIN));
    assign detail_wdata = wr_fwd ? rs_b : (r_phase == PH_FWD_C) ? detail_rd : scratch_rd;

    assign mac_data = (r_phase == PH_FWD_A && r_lv == 3'd0) ? sample_rd :
                      (r_phase == PH_FWD_B) ? detail_rd : scratch_rd;

    assign mac_ctl.valid  = r_v1;
    assign mac_ctl.clear  = (r_state == S_WR);
    assign mac_ctl.coef_a = r_ca;
    assign mac_ctl.coef_b = r_cb;

    wpt_ram #(.WIDTH(wpt_pkg::DATA_W), .DEPTH(wpt_pkg::DEPTH)) u_sample (
        .i_clk(i_clk), .i_we(sample_we), .i_waddr(sample_waddr),
        .i_wdata(sample_wdata), .i_raddr(rd_addr), .o_rdata(sample_rd)
    );

    wpt_ram #(.WIDTH(wpt_pkg::DATA_W), .DEPTH(wpt_pkg::DEPTH)) u_scratch (
        .i_clk(i_clk), .i_we(scratch_we), .i_waddr(wr_addr),
        .i_wdata(scratch_wdata), .i_raddr(rd_addr), .o_rdata(scratch_rd)
    );

    wpt_ram #(.WIDTH(wpt_pkg::DATA_W), .DEPTH(wpt_pkg::DEPTH)) u_detail (
        .i_clk(i_clk), .i_we(detail_we), .i_waddr(wr_addr),
        .i_wdata(detail_wdata), .i_raddr(rd_addr), .o_rdata(detail_rd)
    );

    wpt_mac u_mac (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(mac_ctl),
        .i_data($signed(mac_data)), .o_acc_a(acc_a), .o_acc_b(acc_b)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= PH_FWD_A;
            r_load_count <= '0;
            r_lv         <= '0;
            r_blk        <= '0;
            r_j          <= '0;
            r_t          <= '0;
            r_sub        <= 1'b0;
            r_res_det    <= 1'b0;
            r_v1         <= 1'b0;
            r_ov1        <= 1'b0;
            r_ol1        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_last   <= 1'b0;
        end else begin
            r_v1        <= (r_state == S_ISSUE);
            r_ov1       <= (r_state == S_OUT);
            r_ol1       <= (r_state == S_OUT) && (r_j == mask_n);
            r_out_valid <= r_ov1;
            r_out_last  <= r_ol1;
            case (r_state)
                S_IDLE: begin
                    if (load) begin
                        if (cnt7 >= n7) begin
                            r_load_count <= '0;
                            r_res_det    <= !i_action && (st_eff != 3'd0);
                            r_j          <= '0;
                            r_t          <= '0;
                            r_sub        <= 1'b0;
                            r_blk        <= '0;
                            if (st_eff == 3'd0) begin
                                r_state <= S_OUT;
                            end else if (!i_action) begin
                                r_lv    <= 3'd0;
                                r_phase <= PH_FWD_A;
                                r_state <= S_ISSUE;
                            end else begin
                                r_lv    <= st_eff;
                                r_phase <= PH_INV_CP;
                                r_state <= S_CP_RD;
                            end
                        end else begin
                            r_load_count <= cnt7[5:0];
                        end
                    end
                end
                S_ISSUE: begin
                    if (is_inv) begin
                        r_sub <= !r_sub;
                        if (r_sub) begin
                            r_t <= r_t + 3'd2;
                        end
                    end else begin
                        r_t <= r_t + 3'd1;
                    end
                    if (issue_last) begin
                        r_state <= S_D1;
                    end
                end
                S_D1: r_state <= S_D2;
                S_D2: r_state <= S_WR;
                S_CP_RD: r_state <= S_CP_WR;
                S_WR, S_CP_WR: begin
                    r_sub <= 1'b0;
                    if (!j_last) begin
                        r_j     <= r_j + 6'd1;
                        r_t     <= is_inv ? {2'b0, !r_j[0]} : 3'd0;
                        r_state <= (r_state == S_WR) ? S_ISSUE : S_CP_RD;
                    end else begin
                        r_j <= '0;
                        r_t <= '0;
                        case (r_phase)
                            PH_FWD_A: begin
                                if (r_lv == 3'd0) begin
                                    r_blk <= '0;
                                    r_lv  <= r_lv + 3'd1;
                                    if (r_lv + 3'd1 == st_eff) begin
                                        r_phase <= PH_FWD_FIN;
                                        r_state <= S_CP_RD;
                                    end else begin
                                        r_state <= S_ISSUE;
                                    end
                                end else begin
                                    r_phase <= PH_FWD_B;
                                    r_state <= S_ISSUE;
                                end
                            end
                            PH_FWD_B: begin
                                r_phase <= PH_FWD_C;
                                r_state <= S_CP_RD;
                            end
                            PH_FWD_C: begin
                                if (r_blk == last_blk) begin
                                    r_blk <= '0;
                                    r_lv  <= r_lv + 3'd1;
                                    if (r_lv + 3'd1 == st_eff) begin
                                        r_phase <= PH_FWD_FIN;
                                        r_state <= S_CP_RD;
                                    end else begin
                                        r_phase <= PH_FWD_A;
                                        r_state <= S_ISSUE;
                                    end
                                end else begin
                                    r_blk   <= r_blk + 5'd1;
                                    r_phase <= PH_FWD_A;
                                    r_state <= S_ISSUE;
                                end
                            end
                            PH_FWD_FIN: begin
                                if (r_blk == last_blk) begin
                                    r_state <= S_OUT;
                                end else begin
                                    r_blk   <= r_blk + 5'd1;
                                    r_state <= S_CP_RD;
                                end
                            end
                            PH_INV_CP: begin
                                r_phase <= PH_INV_SY;
                                r_state <= S_ISSUE;
                            end
                            default: begin
                                if (r_blk == last_blk) begin
                                    if (r_lv == 3'd1) begin
                                        r_state <= S_OUT;
                                    end else begin
                                        r_lv    <= r_lv - 3'd1;
                                        r_blk   <= '0;
                                        r_phase <= PH_INV_CP;
                                        r_state <= S_CP_RD;
                                    end
                                end else begin
                                    r_blk   <= r_blk + 5'd1;
                                    r_phase <= PH_INV_CP;
                                    r_state <= S_CP_RD;
                                end
                            end
                        endcase
                    end
                end
                S_OUT: begin
                    if (r_j == mask_n) begin
                        r_j     <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_j <= r_j + 6'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
        r_ca        <= coef_a;
        r_cb        <= coef_b;
        r_out_value <= r_res_det ? detail_rd : sample_rd;
    end

    assign o_valid     = r_out_valid;
    assign o_out_last  = r_out_last;
    assign o_out_value = $signed(r_out_value);

    // checks
    a_last_has_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_last |-> o_valid)
        else $error("last flag without a result");

    a_start_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> (r_load_count == 6'd0))
        else $error("load count not cleared at tile completion");

    a_write_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> ($past(r_state) == S_D2))
        else $error("result written before the mac drained");

    a_gap_after_tile: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_last) |=> !o_valid)
        else $error("result right after the end of a tile");

endmodule
